/* rtl/core/md5_byte_stream_hasher_top_macros.svh */
// ----------------------------------------------------------------------------
// MD5 byte-stream hasher: assertion macros
// Concurrent checks sampled on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MD5_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define MD5_BYTE_STREAM_HASHER_TOP_MACROS_SVH

// Same-cycle implication.
`define MD5BSH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MD5BSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/md5bsh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5bsh_pkg
// Shared types, constants and round tables of the MD5 byte-stream hasher.
// ----------------------------------------------------------------------------
package md5bsh_pkg;

    // Classification of an input beat
    typedef enum logic
    {
        KIND_DATA   = 1'b0,
        KIND_FINISH = 1'b1
    } item_kind_t;

    // Input beat
    typedef struct packed
    {
        logic       func;
        logic [7:0] data_byte;
    } msg_item_t;

    // Output beat
    typedef struct packed
    {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } digest_item_t;

    // Head of the queue as seen by the back end
    typedef struct packed
    {
        logic       valid;
        item_kind_t kind;
        logic [7:0] data_byte;
    } q_head_t;

    // Initial chaining words
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    // Padding
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [1:0] WORD_LAST  = 2'd3;

    // Additive constant of each round
    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    // Rotate amount: four per quarter, chosen by the low two round bits
    function automatic logic [4:0] round_s(input logic [5:0] r);
        logic [4:0] s;
        begin
            unique case ({r[5:4], r[1:0]})
                4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
                4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
                4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
                4'd10: s = 5'd16;  4'd11: s = 5'd23;
                4'd12: s = 5'd6;   4'd13: s = 5'd10;
                4'd14: s = 5'd15;  4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    // Message word used by a round (all arithmetic mod 16)
    function automatic logic [3:0] round_g(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] g;
        begin
            lo = r[3:0];
            unique case (r[5:4])
                2'd0:    g = lo;
                2'd1:    g = 4'(lo * 4'd5) + 4'd1;
                2'd2:    g = 4'(lo * 4'd3) + 4'd5;
                2'd3:    g = 4'(lo * 4'd7);
                default: g = lo;
            endcase
            return g;
        end
    endfunction

    // Boolean function of a round
    function automatic logic [31:0] round_f(input logic [1:0] quarter,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        begin
            unique case (quarter)
                2'd0:    f = (b & c) | (~b & d);
                2'd1:    f = (d & b) | (~d & c);
                2'd2:    f = b ^ c ^ d;
                2'd3:    f = c ^ (b | ~d);
                default: f = b ^ c ^ d;
            endcase
            return f;
        end
    endfunction

    // Rotate left by 0..31
    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        begin
            dbl = {x, x} << s;
            return dbl[63:32];
        end
    endfunction

endpackage

/* rtl/core/md5bsh_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5bsh_front
// Input side: accepts message beats, classifies them and queues them for the
// back end so that either side can stall on its own.
// ----------------------------------------------------------------------------
module md5bsh_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    output logic                   msg_stall,
    input  md5bsh_pkg::msg_item_t  msg,
    output md5bsh_pkg::q_head_t    q_head,
    input  logic                   q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    typedef struct packed
    {
        md5bsh_pkg::item_kind_t kind;
        logic [7:0]             data_byte;
    } q_entry_t;

    q_entry_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push;
    logic             pop;
    q_entry_t         new_entry;

    // Classify the incoming beat
    always_comb
    begin
        new_entry.kind      = msg.func ? md5bsh_pkg::KIND_FINISH : md5bsh_pkg::KIND_DATA;
        new_entry.data_byte = msg.data_byte;
    end

    assign msg_stall = (fill_reg == CNT_FULL);
    assign push      = msg_valid && !msg_stall;
    assign pop       = q_pop && (fill_reg != '0);

    // Present the oldest entry
    always_comb
    begin
        q_head.valid     = (fill_reg != '0);
        q_head.kind      = entry_reg[rd_ptr_reg].kind;
        q_head.data_byte = entry_reg[rd_ptr_reg].data_byte;
    end

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

/* rtl/core/md5bsh_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5bsh_back
// Execution side: fills the 64-byte block, pads at finish, runs one MD5
// round per cycle and drives the digest words through an output register.
// ----------------------------------------------------------------------------
module md5bsh_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  md5bsh_pkg::q_head_t      q_head,
    output logic                     q_pop,
    output logic                     digest_valid,
    input  logic                     digest_stall,
    output md5bsh_pkg::digest_item_t digest
);

    typedef enum logic [5:0]
    {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    logic [31:0]  chain_reg [4];
    logic [31:0]  chain_next [4];
    logic [63:0]  count_reg, count_next;
    logic [63:0]  bits_reg, bits_next;
    logic         pad_busy_reg, pad_busy_next;
    logic         pad_first_reg, pad_first_next;
    logic         len_phase_reg, len_phase_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [31:0]  a_next, b_next, c_next, d_next;
    logic [1:0]   emit_idx_reg, emit_idx_next;
    logic         out_valid_reg, out_valid_next;
    md5bsh_pkg::digest_item_t out_reg, out_next;

    // Block memory: sixteen little-endian words, byte-lane writes
    logic [31:0]  blk_mem [16];
    logic [31:0]  rdata_reg;
    logic [3:0]   rd_addr;
    logic         wr_en;
    logic [7:0]   wr_byte;
    logic [5:0]   offset;

    // Round datapath
    logic [31:0]  f_val;
    logic [31:0]  t_val;
    logic [5:0]   rnd_inc;
    logic         out_load;

    assign offset  = count_reg[5:0];
    assign rnd_inc = rnd_reg + 6'd1;

    // One MD5 round on the current working words
    always_comb
    begin
        f_val = md5bsh_pkg::round_f(rnd_reg[5:4], b_reg, c_reg, d_reg);
        t_val = a_reg + f_val + md5bsh_pkg::round_k(rnd_reg) + rdata_reg;
    end

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || !digest_stall);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        bits_next      = bits_reg;
        pad_busy_next  = pad_busy_reg;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        rnd_next       = rnd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        emit_idx_next  = emit_idx_reg;
        chain_next     = chain_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_byte        = md5bsh_pkg::ZERO_BYTE;
        rd_addr        = '0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        // Drop the output beat once taken
        if (out_valid_reg && !digest_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.kind == md5bsh_pkg::KIND_DATA)
                    begin
                        wr_en      = 1'b1;
                        wr_byte    = q_head.data_byte;
                        count_next = count_reg + 64'd1;
                        if (offset == md5bsh_pkg::BLOCK_LAST)
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        bits_next      = {count_reg[60:0], 3'b000};
                        pad_busy_next  = 1'b1;
                        pad_first_next = 1'b1;
                        len_phase_next = 1'b0;
                        state_next     = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // Append the marker byte, zeros, then the bit length
                wr_en          = 1'b1;
                count_next     = count_reg + 64'd1;
                pad_first_next = 1'b0;
                if (pad_first_reg)
                begin
                    wr_byte = md5bsh_pkg::PAD_BYTE;
                end
                else if (len_phase_reg || offset == md5bsh_pkg::LEN_OFFSET)
                begin
                    wr_byte        = bits_reg[{offset[2:0], 3'b000} +: 8];
                    len_phase_next = 1'b1;
                end
                else
                begin
                    wr_byte = md5bsh_pkg::ZERO_BYTE;
                end
                if (offset == md5bsh_pkg::BLOCK_LAST)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // Copy chaining words and fetch the first message word
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                rnd_next   = '0;
                rd_addr    = md5bsh_pkg::round_g(6'd0);
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                a_next   = d_reg;
                d_next   = c_reg;
                c_next   = b_reg;
                b_next   = b_reg + md5bsh_pkg::rotl(t_val, md5bsh_pkg::round_s(rnd_reg));
                rnd_next = rnd_inc;
                rd_addr  = md5bsh_pkg::round_g(rnd_inc);
                if (rnd_reg == md5bsh_pkg::ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (!pad_busy_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_phase_reg)
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_next.digest_word = chain_reg[emit_idx_reg];
                    out_next.word_index  = emit_idx_reg;
                    out_next.last_word   = (emit_idx_reg == md5bsh_pkg::WORD_LAST);
                    out_valid_next       = 1'b1;
                    emit_idx_next        = emit_idx_reg + 2'd1;
                    if (emit_idx_reg == md5bsh_pkg::WORD_LAST)
                    begin
                        // Return to the initial chaining state
                        chain_next[0] = md5bsh_pkg::IV0;
                        chain_next[1] = md5bsh_pkg::IV1;
                        chain_next[2] = md5bsh_pkg::IV2;
                        chain_next[3] = md5bsh_pkg::IV3;
                        count_next    = '0;
                        pad_busy_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg[0]  <= md5bsh_pkg::IV0;
            chain_reg[1]  <= md5bsh_pkg::IV1;
            chain_reg[2]  <= md5bsh_pkg::IV2;
            chain_reg[3]  <= md5bsh_pkg::IV3;
            count_reg     <= '0;
            pad_busy_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            rnd_reg       <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            count_reg     <= count_next;
            pad_busy_reg  <= pad_busy_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
            rnd_reg       <= rnd_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        out_reg  <= out_next;
    end

    // Block memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            blk_mem[offset[5:2]][{offset[1:0], 3'b000} +: 8] <= wr_byte;
        end
        rdata_reg <= blk_mem[rd_addr];
    end

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

endmodule

/* rtl/core/md5_byte_stream_hasher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_byte_stream_hasher_top
// MD5 over a byte stream: message bytes in, four digest words out per message.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel (msg_valid/msg_stall/msg): one beat per byte with func = 0,
//   then one beat with func = 1 to close the message. An empty message is a
//   lone finish beat.
//   digest channel (digest_valid/digest_stall/digest): four beats per
//   message, word_index 0..3, last_word set on the fourth.
// Flow:
//   The back end writes each data byte into the block memory. The 64th byte
//   of a block starts a compression (word fetch, 64 rounds, chaining add) in
//   the single round unit, during which no bytes are taken. A finish beat
//   writes the padding bytes one at a time, runs one or two compressions,
//   then loads word 0 into the output register.
//   A QUEUE_DEPTH-entry queue absorbs input beats while the back end works.
// Reset: clears the queue, the byte count and the output valid flag and loads
//   the initial chaining words; the block memory is not cleared.
// Stall: a stalled digest beat holds; the back end waits with the next word
//   and bytes keep queueing until the queue fills and msg_stall rises.
// ----------------------------------------------------------------------------
`include "md5_byte_stream_hasher_top_macros.svh"

module md5_byte_stream_hasher_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     msg_valid,
    output logic                     msg_stall,
    input  md5bsh_pkg::msg_item_t    msg,
    output logic                     digest_valid,
    input  logic                     digest_stall,
    output md5bsh_pkg::digest_item_t digest
);

    md5bsh_pkg::q_head_t q_head;
    logic                q_pop;

    // Accept and queue input beats
    md5bsh_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    // Hash queued beats and emit the digest
    md5bsh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    // Checks
    `MD5BSH_ASSERT_NOW(a_pop_needs_head, q_pop, q_head.valid, "pop from an empty queue")
    `MD5BSH_ASSERT_NOW(a_last_on_word3, digest_valid, digest.last_word == (digest.word_index == md5bsh_pkg::WORD_LAST), "last_word out of step with word_index")
    `MD5BSH_ASSERT_NEXT(a_words_back_to_back, digest_valid && !digest_stall && !digest.last_word, digest_valid, "gap inside a digest")
    `MD5BSH_ASSERT_NEXT(a_index_steps, digest_valid && !digest_stall && !digest.last_word, digest.word_index == 2'($past(digest.word_index) + 2'd1), "digest word index skipped")

endmodule

/* sim/md5_byte_stream_hasher_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_byte_stream_hasher_top_tb
// Drives message bytes and finish beats into the MD5 byte-stream hasher and
// checks every digest beat. An MD5 model inside the bench predicts the digest
// of each message. A short table covers the empty message, the standard short
// test vectors and byte extremes. Random messages of mixed lengths follow,
// many of them sized around the padding boundaries. Both sides idle at random,
// and the receiver once holds off long enough for the input queue to fill.
// ----------------------------------------------------------------------------
module md5_byte_stream_hasher_top_tb;

    localparam int          RANDOM_ITEMS    = 340;
    localparam int          HOLD_OFF_AFTER  = 25;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          DRAIN_CYCLES    = 300;
    localparam int          REPORT_LIMIT    = 10;
    localparam logic [7:0]  PAD_MARK        = 8'h80;
    localparam logic [5:0]  LEN_SLOT        = 6'd56;
    localparam logic [31:0] INIT_A          = 32'h67452301;
    localparam logic [31:0] INIT_B          = 32'hefcdab89;
    localparam logic [31:0] INIT_C          = 32'h98badcfe;
    localparam logic [31:0] INIT_D          = 32'h10325476;

    // Well-known digests, written as the usual hex byte string
    localparam logic [127:0] DIGEST_EMPTY = 128'hd41d8cd98f00b204e9800998ecf8427e;
    localparam logic [127:0] DIGEST_A     = 128'h0cc175b9c0f1b6a831c399e269772661;
    localparam logic [127:0] DIGEST_ABC   = 128'h900150983cd24fb0d6963f7d28e17f72;

    typedef struct packed
    {
        md5bsh_pkg::msg_item_t beat;
        logic                  has_known;
        logic [127:0]          known_hex;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     msg_valid = 1'b0;
    logic                     msg_stall;
    md5bsh_pkg::msg_item_t    msg = '0;
    logic                     digest_valid;
    logic                     digest_stall = 1'b0;
    md5bsh_pkg::digest_item_t digest;

    // Sine-derived additive constants and per-quarter rotate amounts
    logic [31:0] md5_k [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    int md5_rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // Predictor state
    logic [31:0] hash_state [4];
    logic [7:0]  block_bytes [64];
    logic [63:0] msg_len;

    md5bsh_pkg::digest_item_t digest_expect [$];
    stim_row_t                directed_rows [$];
    int                       fault_count = 0;
    int                       words_received = 0;
    bit                       tx_idle = 1'b1;

    md5_byte_stream_hasher_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    always #6 clk = ~clk;

    // Return the chaining words to their initial values
    function automatic void hash_restart();
        hash_state[0] = INIT_A;
        hash_state[1] = INIT_B;
        hash_state[2] = INIT_C;
        hash_state[3] = INIT_D;
        msg_len = '0;
    endfunction

    // Run the 64 rounds over the buffered block and fold into the chain
    function automatic void md5_compress_block();
        logic [31:0] m [16];
        logic [31:0] a, b, c, d, f, t;
        int g;
        int s;
        for (int i = 0; i < 16; i++)
            m[i] = {block_bytes[4 * i + 3], block_bytes[4 * i + 2],
                    block_bytes[4 * i + 1], block_bytes[4 * i]};
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        for (int r = 0; r < 64; r++)
        begin
            case (r / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            s = md5_rot[4 * (r / 16) + r % 4];
            t = a + f + md5_k[r] + m[g];
            a = d;
            d = c;
            c = b;
            b = b + ((t << s) | (t >> (32 - s)));
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
    endfunction

    // Buffer one byte; compress once the block is full
    function automatic void md5_absorb_byte(input logic [7:0] value);
        block_bytes[msg_len[5:0]] = value;
        msg_len = msg_len + 64'd1;
        if (msg_len[5:0] == 6'd0)
            md5_compress_block();
    endfunction

    // Pad, append the bit length and return the digest words (word i at 32*i)
    function automatic logic [127:0] md5_finish_message();
        logic [63:0]  bit_len;
        logic [127:0] words;
        bit_len = msg_len << 3;
        md5_absorb_byte(PAD_MARK);
        while (msg_len[5:0] != LEN_SLOT)
            md5_absorb_byte(8'h00);
        for (int i = 0; i < 8; i++)
            md5_absorb_byte(bit_len[8 * i +: 8]);
        for (int i = 0; i < 4; i++)
            words[32 * i +: 32] = hash_state[i];
        hash_restart();
        return words;
    endfunction

    // Turn a digest byte string into its four little-endian words
    function automatic logic [127:0] digest_to_words(input logic [127:0] hex);
        logic [127:0] words;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                words[32 * i + 8 * j +: 8] = hex[127 - 8 * (4 * i + j) -: 8];
        return words;
    endfunction

    function automatic stim_row_t make_row(input md5bsh_pkg::item_kind_t kind,
                                           input logic [7:0] value,
                                           input logic known, input logic [127:0] hex);
        stim_row_t row;
        row.beat.func      = kind;
        row.beat.data_byte = value;
        row.has_known      = known;
        row.known_hex      = hex;
        return row;
    endfunction

    function automatic void report_fault(input string what);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, what);
    endfunction

    // Compare one digest beat with the oldest expected word
    task automatic check_digest(input md5bsh_pkg::digest_item_t got);
        md5bsh_pkg::digest_item_t want;
        if (digest_expect.size() == 0)
        begin
            report_fault($sformatf("unexpected digest beat word %08h index %0d last %0b",
                                   got.digest_word, got.word_index, got.last_word));
            return;
        end
        want = digest_expect.pop_front();
        if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
            got.last_word !== want.last_word)
            report_fault($sformatf(
                "digest mismatch: word %08h/%08h index %0d/%0d last %0b/%0b (exp/act)",
                want.digest_word, got.digest_word, want.word_index, got.word_index,
                want.last_word, got.last_word));
    endtask

    // Offer one beat, wait for acceptance, then update the prediction
    task automatic send_beat(input md5bsh_pkg::msg_item_t beat, input logic has_known,
                             input logic [127:0] known_words);
        int gap;
        logic [127:0] words;
        md5bsh_pkg::digest_item_t item;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            msg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg       <= beat;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        if (beat.func == md5bsh_pkg::KIND_DATA)
            md5_absorb_byte(beat.data_byte);
        else
        begin
            words = md5_finish_message();
            if (has_known)
                words = known_words;
            for (int i = 0; i < 4; i++)
            begin
                item.digest_word = words[32 * i +: 32];
                item.word_index  = 2'(i);
                item.last_word   = (i == 3);
                digest_expect.push_back(item);
            end
        end
    endtask

    // Digest side: check accepted beats, draw stalls, one long hold-off
    initial
    begin : digest_sink
        int stall_left;
        bit rx_idle;
        stall_left = 0;
        rx_idle    = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (digest_valid === 1'b1 && digest_stall === 1'b0)
            begin
                check_digest(digest);
                words_received++;
                if (words_received % 8 == 0)
                    rx_idle = ($urandom_range(0, 2) != 0);
                stall_left = rx_idle ? $urandom_range(0, 11) : 0;
                // hold the next word back so the input queue backs up
                if (words_received == HOLD_OFF_AFTER)
                    stall_left = HOLD_OFF_CYCLES;
            end
            else if (stall_left > 0)
                stall_left--;
            digest_stall <= (stall_left > 0);
        end
    end

    // Bound the run
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Message side: reset, directed table, random messages, drain
    initial
    begin : msg_source
        int boundary_lens [6];
        int msg_bytes;
        int random_items;
        int sel;
        md5bsh_pkg::msg_item_t beat;
        boundary_lens = '{55, 56, 63, 64, 119, 120};
        random_items  = 0;
        hash_restart();

        // empty messages back to back, with either extreme on the ignored byte
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_FINISH, 8'h00, 1'b1, DIGEST_EMPTY));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_FINISH, 8'hff, 1'b1, DIGEST_EMPTY));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_DATA,   8'h61, 1'b0, '0));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_FINISH, 8'h5a, 1'b1, DIGEST_A));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_DATA,   8'h61, 1'b0, '0));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_DATA,   8'h62, 1'b0, '0));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_DATA,   8'h63, 1'b0, '0));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_FINISH, 8'ha5, 1'b1, DIGEST_ABC));
        // byte extremes, including the pad value itself as data
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_DATA,   8'h00, 1'b0, '0));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_DATA,   8'hff, 1'b0, '0));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_DATA,   8'h80, 1'b0, '0));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_DATA,   8'h7f, 1'b0, '0));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_FINISH, 8'h00, 1'b0, '0));
        directed_rows.push_back(make_row(md5bsh_pkg::KIND_FINISH, 8'hff, 1'b1, DIGEST_EMPTY));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].has_known,
                      digest_to_words(directed_rows[i].known_hex));

        // random messages; many short, some around the padding boundaries
        while (random_items < RANDOM_ITEMS)
        begin
            tx_idle = ($urandom_range(0, 2) != 0);
            sel     = $urandom_range(0, 9);
            if (sel < 5)
                msg_bytes = $urandom_range(0, 20);
            else if (sel < 8)
                msg_bytes = $urandom_range(52, 72);
            else if (sel == 8)
                msg_bytes = boundary_lens[$urandom_range(0, 5)];
            else
                msg_bytes = $urandom_range(0, 150);
            for (int i = 0; i < msg_bytes; i++)
            begin
                beat.func      = md5bsh_pkg::KIND_DATA;
                beat.data_byte = 8'($urandom_range(0, 255));
                send_beat(beat, 1'b0, '0);
            end
            beat.func      = md5bsh_pkg::KIND_FINISH;
            beat.data_byte = 8'($urandom_range(0, 255));
            send_beat(beat, 1'b0, '0);
            random_items += msg_bytes + 1;
        end
        msg_valid <= 1'b0;

        // drain outstanding digests, then watch for strays
        while (digest_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && digest_expect.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/md5bsh_pkg.sv
rtl/core/md5bsh_front.sv
rtl/core/md5bsh_back.sv
rtl/core/md5_byte_stream_hasher_top.sv
sim/md5_byte_stream_hasher_top_tb.sv
